### rtl/irla_pkg.sv
// irla_pkg: shared widths, constants and register indexes for the infrared
// range linearize/average block. No dependencies; compiled first.
package irla_pkg;

   // default build parameters
   localparam int RING_DEPTH_DEFAULT = 4;
   localparam int ADC_BITS_DEFAULT   = 12;

   // result field widths
   localparam int MV_W     = 12;
   localparam int DIST_W   = 8;
   localparam int MARGIN_W = 6;

   // configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = 1;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_CALIBRATION_MARGIN = 1'b0,
      REG_UNUSED             = 1'b1
   } csr_index_type;

   // scaling to millivolts
   localparam logic [MV_W-1:0] MV_FULL_SCALE = 12'd3000;

   // segment bounds in millivolts
   localparam logic [MV_W-1:0] SEG_HIGH_MIN = 12'd850;
   localparam logic [MV_W-1:0] SEG_HIGH_MAX = 12'd2150;
   localparam logic [MV_W-1:0] SEG_LOW_MIN  = 12'd400;
   localparam logic [MV_W-1:0] SEG_HIGH_REF = 12'd2575;
   localparam logic [MV_W-1:0] SEG_LOW_REF  = 12'd1150;

   // 3*n/86 as n*18291 >> 19, exact for n up to 1724
   localparam int                SEG_HIGH_RECIP_W = 15;
   localparam logic [14:0]       SEG_HIGH_RECIP   = 15'd18291;
   localparam int                SEG_HIGH_SHIFT   = 19;
   // n/5 as n*820 >> 12, exact for n below 1024
   localparam int                SEG_LOW_RECIP_W  = 10;
   localparam logic [9:0]        SEG_LOW_RECIP    = 10'd820;
   localparam int                SEG_LOW_SHIFT    = 12;

   // codes and reset values
   localparam logic [DIST_W-1:0]   OUT_OF_RANGE_CM = 8'd160;
   localparam logic [DIST_W-1:0]   LIMIT_RESET_CM  = 8'd35;
   localparam logic [MARGIN_W-1:0] MARGIN_RESET_CM = 6'd5;

endpackage

### rtl/irla_req_if.sv
// irla_req_if: valid/ready request channel carrying one converter sample.
// Depends on irla_pkg for the default sample width.
interface irla_req_if #(
   parameter int ADC_BITS = irla_pkg::ADC_BITS_DEFAULT
);
   logic                valid;
   logic                ready;
   logic [ADC_BITS-1:0] adc_sample;

   modport source (output valid, output adc_sample, input ready);
   modport sink   (input valid, input adc_sample, output ready);
endinterface

### rtl/irla_rsp_if.sv
// irla_rsp_if: valid/ready result channel for voltage, distance, average and
// landing limit. Depends on irla_pkg for field widths.
interface irla_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [irla_pkg::MV_W-1:0]     voltage_mv;
   logic [irla_pkg::DIST_W-1:0]   distance_cm;
   logic [irla_pkg::DIST_W-1:0]   average_cm;
   logic [irla_pkg::DIST_W-1:0]   landing_limit_cm;
   logic                          calibrated;

   modport source (output valid, output voltage_mv, output distance_cm,
                   output average_cm, output landing_limit_cm, output calibrated,
                   input ready);
   modport sink   (input valid, input voltage_mv, input distance_cm,
                   input average_cm, input landing_limit_cm, input calibrated,
                   output ready);
endinterface

### rtl/ir_range_linearize_average_unit.sv
// ir_range_linearize_average_unit: infrared range sample linearizer with ring
// averaging and one-time landing limit calibration.
// Depends on irla_pkg, irla_req_if and irla_rsp_if.
//
// Usage:
//   req_ch  - valid/ready request channel, one raw converter sample each.
//   rsp_ch  - valid/ready result channel, exactly one result per request:
//             millivolts, linearized distance, ring average, landing limit
//             and calibrated flag.
//   csr_*   - APB-style port with one register, calibration_margin at byte
//             address 0; pready is always high, reads return the register.
// Pipeline: a request accepted passes through the sample, millivolt, distance,
//   ring/sum and result registers before its result is valid.
// Throughput: one request per cycle while rsp_ch.ready is high; every stage has
//   its own valid bit, so requests keep entering while a result waits as long as a stage is free.
// Stall: when rsp_ch.ready is low the result register holds, stages behind
//   it fill up and req_ch.ready drops once all five are occupied.
// Reset (synchronous, active high): pipeline emptied, ring filled with the
//   out-of-range code 160, write index 0, limit 35, margin 5, uncalibrated.
module ir_range_linearize_average_unit #(
   parameter int RING_DEPTH = irla_pkg::RING_DEPTH_DEFAULT,
   parameter int ADC_BITS   = irla_pkg::ADC_BITS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   irla_req_if.sink                         req_ch,
   irla_rsp_if.source                       rsp_ch,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [irla_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [irla_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [irla_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready
);

   localparam int MV_W      = irla_pkg::MV_W;
   localparam int DIST_W    = irla_pkg::DIST_W;
   localparam int MARGIN_W  = irla_pkg::MARGIN_W;
   localparam int IDX_W     = $clog2(RING_DEPTH);
   localparam int SUM_W     = DIST_W + IDX_W;
   localparam int AVG_SHIFT = SUM_W + IDX_W;
   localparam int AVG_RECIP = ((1 << AVG_SHIFT) + RING_DEPTH - 1) / RING_DEPTH;
   localparam int RECIP_W   = AVG_SHIFT + 1;
   localparam int MVP_W     = ADC_BITS + MV_W;
   localparam int HIP_W     = MV_W + irla_pkg::SEG_HIGH_RECIP_W;
   localparam int LOP_W     = MV_W + irla_pkg::SEG_LOW_RECIP_W;
   localparam int AVGP_W    = SUM_W + RECIP_W;
   localparam int ADDR_LSB  = 2;

   // ---------------- configuration port ----------------
   logic [MARGIN_W-1:0]            margin_ff, margin_in;
   irla_pkg::csr_index_type        csr_index;
   logic                           csr_write;

   assign csr_index  = irla_pkg::csr_index_type'(csr_paddr[ADDR_LSB +: irla_pkg::CSR_IDX_W]);
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      margin_in  = margin_ff;
      csr_prdata = '0;
      case (csr_index)
         irla_pkg::REG_CALIBRATION_MARGIN: begin
            if (csr_write) begin
               margin_in = csr_pwdata[MARGIN_W-1:0];
            end
            csr_prdata = irla_pkg::CSR_DATA_W'(margin_ff);
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   // ---------------- stage handshake ----------------
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, out_valid_ff;
   logic s1_en, s2_en, s3_en, s4_en, out_en;

   assign out_en = !out_valid_ff || rsp_ch.ready;
   assign s4_en  = !s4_valid_ff || out_en;
   assign s3_en  = !s3_valid_ff || s4_en;
   assign s2_en  = !s2_valid_ff || s3_en;
   assign s1_en  = !s1_valid_ff || s2_en;

   assign req_ch.ready = s1_en;

   // ---------------- stage 1: sample ----------------
   logic [ADC_BITS-1:0] sample_ff;

   // ---------------- stage 2: millivolts ----------------
   logic [MVP_W-1:0] mv_product;
   logic [MV_W-1:0]  s2_mv_ff, s2_mv_in;

   assign mv_product = MVP_W'(sample_ff) * MVP_W'(irla_pkg::MV_FULL_SCALE);
   assign s2_mv_in   = mv_product[ADC_BITS +: MV_W];

   // ---------------- stage 3: linearize ----------------
   logic [MV_W-1:0]   high_diff, low_diff;
   logic [HIP_W-1:0]  high_product;
   logic [LOP_W-1:0]  low_product;
   logic              in_high_seg, in_low_seg;
   logic [MV_W-1:0]   s3_mv_ff;
   logic [DIST_W-1:0] s3_dist_ff, s3_dist_in;

   assign high_diff    = irla_pkg::SEG_HIGH_REF - s2_mv_ff;
   assign low_diff     = irla_pkg::SEG_LOW_REF - s2_mv_ff;
   assign high_product = HIP_W'(high_diff) * HIP_W'(irla_pkg::SEG_HIGH_RECIP);
   assign low_product  = LOP_W'(low_diff) * LOP_W'(irla_pkg::SEG_LOW_RECIP);
   assign in_high_seg  = (s2_mv_ff > irla_pkg::SEG_HIGH_MIN) &&
                         (s2_mv_ff < irla_pkg::SEG_HIGH_MAX);
   assign in_low_seg   = (s2_mv_ff > irla_pkg::SEG_LOW_MIN) &&
                         (s2_mv_ff <= irla_pkg::SEG_HIGH_MIN);

   always_comb begin
      if (in_high_seg) begin
         s3_dist_in = high_product[irla_pkg::SEG_HIGH_SHIFT +: DIST_W];
      end else if (in_low_seg) begin
         s3_dist_in = low_product[irla_pkg::SEG_LOW_SHIFT +: DIST_W];
      end else begin
         s3_dist_in = irla_pkg::OUT_OF_RANGE_CM;
      end
   end

   // ---------------- stage 4: ring update and sum ----------------
   logic [DIST_W-1:0] ring_ff [RING_DEPTH];
   logic [DIST_W-1:0] ring_in [RING_DEPTH];
   logic [IDX_W-1:0]  index_ff, index_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic              full_ff, full_in;
   logic [MV_W-1:0]   s4_mv_ff;
   logic [DIST_W-1:0] s4_dist_ff;
   logic              dist_ok;

   assign dist_ok = (s3_dist_ff != irla_pkg::OUT_OF_RANGE_CM);

   always_comb begin
      for (int k = 0; k < RING_DEPTH; k++) begin
         if (!dist_ok) begin
            ring_in[k] = irla_pkg::OUT_OF_RANGE_CM;
         end else if (index_ff == IDX_W'(k)) begin
            ring_in[k] = s3_dist_ff;
         end else begin
            ring_in[k] = ring_ff[k];
         end
      end
      if (!dist_ok || index_ff == IDX_W'(RING_DEPTH - 1)) begin
         index_in = '0;
      end else begin
         index_in = index_ff + 1'b1;
      end
      sum_in = '0;
      for (int k = 0; k < RING_DEPTH; k++) begin
         sum_in = sum_in + SUM_W'(ring_in[k]);
      end
      full_in = (ring_in[RING_DEPTH-1] != irla_pkg::OUT_OF_RANGE_CM);
   end

   // ---------------- result stage: average and calibration ----------------
   logic [AVGP_W-1:0]  avg_product;
   logic [DIST_W-1:0]  avg_cm;
   logic [DIST_W-1:0]  limit_ff, limit_in;
   logic               cal_done_ff, cal_done_in;
   logic [MV_W-1:0]    out_mv_ff;
   logic [DIST_W-1:0]  out_dist_ff, out_avg_ff;
   logic               s4_take;

   assign avg_product = AVGP_W'(sum_ff) * AVGP_W'(RECIP_W'(AVG_RECIP));
   assign avg_cm      = full_ff ? avg_product[AVG_SHIFT +: DIST_W] : irla_pkg::OUT_OF_RANGE_CM;
   assign s4_take     = out_en && s4_valid_ff;

   always_comb begin
      limit_in    = limit_ff;
      cal_done_in = cal_done_ff;
      // the limit is latched once, from the first full-ring average
      if (s4_take && full_ff && !cal_done_ff) begin
         limit_in    = avg_cm + DIST_W'(margin_ff);
         cal_done_in = 1'b1;
      end
   end

   assign rsp_ch.valid            = out_valid_ff;
   assign rsp_ch.voltage_mv       = out_mv_ff;
   assign rsp_ch.distance_cm      = out_dist_ff;
   assign rsp_ch.average_cm       = out_avg_ff;
   assign rsp_ch.landing_limit_cm = limit_ff;
   assign rsp_ch.calibrated       = cal_done_ff;

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         margin_ff    <= irla_pkg::MARGIN_RESET_CM;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         index_ff     <= '0;
         limit_ff     <= irla_pkg::LIMIT_RESET_CM;
         cal_done_ff  <= 1'b0;
         for (int k = 0; k < RING_DEPTH; k++) begin
            ring_ff[k] <= irla_pkg::OUT_OF_RANGE_CM;
         end
      end else begin
         margin_ff   <= margin_in;
         limit_ff    <= limit_in;
         cal_done_ff <= cal_done_in;
         if (s1_en) begin
            s1_valid_ff <= req_ch.valid;
         end
         if (s2_en) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (s3_en) begin
            s3_valid_ff <= s2_valid_ff;
         end
         if (s4_en) begin
            s4_valid_ff <= s3_valid_ff;
         end
         if (out_en) begin
            out_valid_ff <= s4_valid_ff;
         end
         if (s4_en && s3_valid_ff) begin
            index_ff <= index_in;
            for (int k = 0; k < RING_DEPTH; k++) begin
               ring_ff[k] <= ring_in[k];
            end
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (s1_en && req_ch.valid) begin
         sample_ff <= req_ch.adc_sample;
      end
      if (s2_en && s1_valid_ff) begin
         s2_mv_ff <= s2_mv_in;
      end
      if (s3_en && s2_valid_ff) begin
         s3_mv_ff   <= s2_mv_ff;
         s3_dist_ff <= s3_dist_in;
      end
      if (s4_en && s3_valid_ff) begin
         s4_mv_ff   <= s3_mv_ff;
         s4_dist_ff <= s3_dist_ff;
         sum_ff     <= sum_in;
         full_ff    <= full_in;
      end
      if (s4_take) begin
         out_mv_ff   <= s4_mv_ff;
         out_dist_ff <= s4_dist_ff;
         out_avg_ff  <= avg_cm;
      end
   end

endmodule

### verif/tb_ir_range_linearize_average_unit.sv
// tb_ir_range_linearize_average_unit: self-checking bench for the infrared range
// linearize/average unit; directed table, then random samples under back-pressure.
// Depends on irla_pkg, irla_req_if, irla_rsp_if and ir_range_linearize_average_unit.
module tb_ir_range_linearize_average_unit;

   localparam int SAMPLE_W     = irla_pkg::ADC_BITS_DEFAULT;
   localparam int RING_ENTRIES = irla_pkg::RING_DEPTH_DEFAULT;
   localparam int MV_W         = irla_pkg::MV_W;
   localparam int DIST_W       = irla_pkg::DIST_W;
   localparam int MARGIN_W     = irla_pkg::MARGIN_W;
   localparam int CSR_ADDR_W   = irla_pkg::CSR_ADDR_W;
   localparam int CSR_DATA_W   = irla_pkg::CSR_DATA_W;
   localparam int PHASE_ITEMS  = 350;
   localparam int PAUSE_AT     = 150;
   localparam int DRAIN_CYCLES = 8;
   localparam int CYCLE_LIMIT  = 400000;

   localparam logic [DIST_W-1:0]   OUT_OF_RANGE_CM = irla_pkg::OUT_OF_RANGE_CM;
   localparam logic [DIST_W-1:0]   LIMIT_RESET_CM  = irla_pkg::LIMIT_RESET_CM;
   localparam logic [MARGIN_W-1:0] MARGIN_RESET_CM = irla_pkg::MARGIN_RESET_CM;

   // sample codes that land right on a segment or range edge
   localparam logic [SAMPLE_W-1:0] EDGE_SAMPLES [7] = '{
      12'd547, 12'd548, 12'd1160, 12'd1161, 12'd1162, 12'd2935, 12'd2936
   };

   typedef struct packed {
      logic [MV_W-1:0]   voltage_mv;
      logic [DIST_W-1:0] distance_cm;
      logic [DIST_W-1:0] average_cm;
      logic [DIST_W-1:0] landing_limit_cm;
      logic              calibrated;
   } range_reading_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample;
      logic                typed;
      range_reading_type   want;
   } directed_row_type;

   // margin is 63 when the first full ring is seen, so the limit becomes 149 + 63
   localparam directed_row_type DIRECTED_ROWS [17] = '{
      '{12'd0,    1'b1, '{12'd0,    OUT_OF_RANGE_CM, OUT_OF_RANGE_CM, LIMIT_RESET_CM, 1'b0}},
      '{12'd4095, 1'b1, '{12'd2999, OUT_OF_RANGE_CM, OUT_OF_RANGE_CM, LIMIT_RESET_CM, 1'b0}},
      '{12'd547,  1'b1, '{12'd400,  OUT_OF_RANGE_CM, OUT_OF_RANGE_CM, LIMIT_RESET_CM, 1'b0}},
      '{12'd2936, 1'b1, '{12'd2150, OUT_OF_RANGE_CM, OUT_OF_RANGE_CM, LIMIT_RESET_CM, 1'b0}},
      '{12'd548,  1'b1, '{12'd401,  8'd149, OUT_OF_RANGE_CM, LIMIT_RESET_CM, 1'b0}},
      '{12'd548,  1'b1, '{12'd401,  8'd149, OUT_OF_RANGE_CM, LIMIT_RESET_CM, 1'b0}},
      '{12'd548,  1'b1, '{12'd401,  8'd149, OUT_OF_RANGE_CM, LIMIT_RESET_CM, 1'b0}},
      '{12'd548,  1'b1, '{12'd401,  8'd149, 8'd149, 8'd212, 1'b1}},
      '{12'd1161, 1'b0, '0},
      '{12'd1162, 1'b0, '0},
      '{12'd2935, 1'b0, '0},
      '{12'd1,    1'b1, '{12'd0,    OUT_OF_RANGE_CM, OUT_OF_RANGE_CM, 8'd212, 1'b1}},
      '{12'd2000, 1'b0, '0},
      '{12'd1500, 1'b0, '0},
      '{12'd2500, 1'b0, '0},
      '{12'd800,  1'b0, '0},
      '{12'd4095, 1'b1, '{12'd2999, OUT_OF_RANGE_CM, OUT_OF_RANGE_CM, 8'd212, 1'b1}}
   };

   logic clock = 1'b0;
   logic reset;

   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   irla_req_if #(.ADC_BITS(SAMPLE_W)) req_ch ();
   irla_rsp_if rsp_ch ();

   ir_range_linearize_average_unit u_top (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // shadow of the block's state
   logic [DIST_W-1:0]   ring_cm [RING_ENTRIES] = '{default: OUT_OF_RANGE_CM};
   int unsigned         ring_wr       = 0;
   logic                limit_set     = 1'b0;
   logic [DIST_W-1:0]   limit_cm      = LIMIT_RESET_CM;
   logic [MARGIN_W-1:0] margin_cm     = MARGIN_RESET_CM;

   range_reading_type pending_readings [$];
   int unsigned       sender_idle_pct    = 0;
   int unsigned       receiver_stall_pct = 0;
   int unsigned       mismatches         = 0;
   int unsigned       cycle_count        = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic range_reading_type predict_reading(input logic [SAMPLE_W-1:0] sample);
      range_reading_type r;
      int unsigned       mv;
      int unsigned       cm;
      int unsigned       sum;
      mv = (3000 * int'(sample)) >> SAMPLE_W;
      if (mv > 850 && mv < 2150) begin
         cm = (3 * (2575 - mv)) / 86;
      end else if (mv > 400 && mv <= 850) begin
         cm = (1150 - mv) / 5;
      end else begin
         cm = OUT_OF_RANGE_CM;
      end
      if (cm != OUT_OF_RANGE_CM) begin
         ring_cm[ring_wr] = DIST_W'(cm);
         ring_wr = (ring_wr + 1) % RING_ENTRIES;
      end else begin
         ring_cm = '{default: OUT_OF_RANGE_CM};
         ring_wr = 0;
      end
      r.average_cm = OUT_OF_RANGE_CM;
      if (ring_cm[RING_ENTRIES-1] != OUT_OF_RANGE_CM) begin
         sum = 0;
         foreach (ring_cm[k]) sum += ring_cm[k];
         r.average_cm = DIST_W'(sum / RING_ENTRIES);
         if (!limit_set) begin
            limit_cm  = r.average_cm + DIST_W'(margin_cm);
            limit_set = 1'b1;
         end
      end
      r.voltage_mv       = MV_W'(mv);
      r.distance_cm      = DIST_W'(cm);
      r.landing_limit_cm = limit_cm;
      r.calibrated       = limit_set;
      return r;
   endfunction

   // mostly in-range runs so the ring fills, with out-of-range noise and edge codes
   function automatic logic [SAMPLE_W-1:0] pick_sample();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 6) return SAMPLE_W'($urandom_range(547, 0));
      if (roll < 12) return SAMPLE_W'($urandom_range(4095, 2936));
      if (roll < 18) return EDGE_SAMPLES[$urandom_range(6)];
      return SAMPLE_W'($urandom_range(2935, 548));
   endfunction

   task automatic send_sample(input logic [SAMPLE_W-1:0] sample, input logic typed,
                              input range_reading_type want);
      range_reading_type predicted;
      while ($urandom_range(99) < sender_idle_pct) begin
         @(negedge clock);
         req_ch.valid <= 1'b0;
      end
      @(negedge clock);
      req_ch.valid      <= 1'b1;
      req_ch.adc_sample <= sample;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      predicted = predict_reading(sample);
      pending_readings.push_back(typed ? want : predicted);
   endtask

   task automatic write_csr(input irla_pkg::csr_index_type idx,
                            input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'(4 * int'(idx));
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      // unused index is dropped by the block
      if (idx == irla_pkg::REG_CALIBRATION_MARGIN) margin_cm = value[MARGIN_W-1:0];
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic drain_readings();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (pending_readings.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   always @(negedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   always @(posedge clock) begin
      range_reading_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_readings.size() == 0) begin
            $error("result with no request outstanding: voltage_mv %0d", rsp_ch.voltage_mv);
            mismatches++;
         end else begin
            want = pending_readings.pop_front();
            if (rsp_ch.voltage_mv !== want.voltage_mv) begin
               $error("voltage_mv: expected %0d, got %0d", want.voltage_mv, rsp_ch.voltage_mv);
               mismatches++;
            end
            if (rsp_ch.distance_cm !== want.distance_cm) begin
               $error("distance_cm: expected %0d, got %0d",
                      want.distance_cm, rsp_ch.distance_cm);
               mismatches++;
            end
            if (rsp_ch.average_cm !== want.average_cm) begin
               $error("average_cm: expected %0d, got %0d", want.average_cm, rsp_ch.average_cm);
               mismatches++;
            end
            if (rsp_ch.landing_limit_cm !== want.landing_limit_cm) begin
               $error("landing_limit_cm: expected %0d, got %0d",
                      want.landing_limit_cm, rsp_ch.landing_limit_cm);
               mismatches++;
            end
            if (rsp_ch.calibrated !== want.calibrated) begin
               $error("calibrated: expected %0d, got %0d", want.calibrated, rsp_ch.calibrated);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("ir_range_linearize_average_unit regression: fail");
         $finish;
      end
   end

   initial begin
      reset             = 1'b1;
      req_ch.valid      = 1'b0;
      req_ch.adc_sample = '0;
      rsp_ch.ready      = 1'b0;
      csr_psel          = 1'b0;
      csr_penable       = 1'b0;
      csr_pwrite        = 1'b0;
      csr_paddr         = '0;
      csr_pwdata        = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      write_csr(irla_pkg::REG_CALIBRATION_MARGIN, 32'd0);
      write_csr(irla_pkg::REG_CALIBRATION_MARGIN, 32'd63);
      foreach (DIRECTED_ROWS[i]) begin
         send_sample(DIRECTED_ROWS[i].sample, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
      end

      for (int phase = 0; phase < 4; phase++) begin
         drain_readings();
         // limit is already latched, so later margin writes must not move it
         case (phase)
            0: begin
               write_csr(irla_pkg::REG_UNUSED, $urandom());
               write_csr(irla_pkg::REG_CALIBRATION_MARGIN, 32'd0);
               sender_idle_pct    = 0;
               receiver_stall_pct = 0;
            end
            1: begin
               write_csr(irla_pkg::REG_CALIBRATION_MARGIN, 32'($urandom_range(63)));
               sender_idle_pct    = 72;
               receiver_stall_pct = 0;
            end
            2: begin
               write_csr(irla_pkg::REG_CALIBRATION_MARGIN, 32'd63);
               sender_idle_pct    = 0;
               receiver_stall_pct = 72;
            end
            default: begin
               write_csr(irla_pkg::REG_UNUSED, 32'd0);
               write_csr(irla_pkg::REG_CALIBRATION_MARGIN, 32'($urandom_range(62, 1)));
               sender_idle_pct    = 30;
               receiver_stall_pct = 30;
            end
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            send_sample(pick_sample(), 1'b0, '0);
            if (phase == 1 && n == PAUSE_AT) drain_readings();
         end
      end

      drain_readings();
      if (mismatches == 0) begin
         $display("ir_range_linearize_average_unit regression: pass");
      end else begin
         $display("ir_range_linearize_average_unit regression: fail");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/irla_pkg.sv
rtl/irla_req_if.sv
rtl/irla_rsp_if.sv
rtl/ir_range_linearize_average_unit.sv
verif/tb_ir_range_linearize_average_unit.sv
